[rtl/isc_pkg.sv]
// isc_pkg: sizes, command and status codes, and the per-cell control bundle
// for the indexed sequence store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isc_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 16;
   localparam int CMD_W    = 3;
   localparam int STAT_W   = 2;
   localparam int LEN_W    = 9;
   localparam int GROUP    = 16;
   localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ   = 3'd0,
      CMD_HEAD   = 3'd1,
      CMD_TAIL   = 3'd2,
      CMD_AT     = 3'd3,
      CMD_DELETE = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_DELETE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [IDX_W-1:0]    pos;
      logic [DATA_W-1:0]   value;
      logic [IDX_W-1:0]    read_pos;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[rtl/isc_cell.sv]
// isc_cell: one entry of the store; shifts toward or away from its neighbors
// on insert and delete, and offers its value when its index is read.
// Depends on isc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isc_cell (
   input  wire logic                          clock,
   input  wire isc_pkg::cell_ctrl_type        ctrl,
   input  wire logic [isc_pkg::IDX_W-1:0]     cell_idx,
   input  wire logic [isc_pkg::DATA_W-1:0]    left_value,
   input  wire logic [isc_pkg::DATA_W-1:0]    right_value,
   output logic      [isc_pkg::DATA_W-1:0]    value,
   output logic      [isc_pkg::DATA_W-1:0]    read_tap
);

   logic [isc_pkg::DATA_W-1:0] value_ff;
   logic [isc_pkg::DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         isc_pkg::OP_INSERT: begin
            if (cell_idx > ctrl.pos) begin
               value_in = left_value;
            end else if (cell_idx == ctrl.pos) begin
               value_in = ctrl.value;
            end
         end
         isc_pkg::OP_DELETE: begin
            if (cell_idx >= ctrl.pos) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   // zero unless this entry is the one being read, so the tree can just or
   assign read_tap = (cell_idx == ctrl.read_pos) ? value_ff : '0;

endmodule

`default_nettype wire

[rtl/isc_read_tree.sv]
// isc_read_tree: two registered or-levels that collect the single selected
// cell value out of the whole row. Depends on isc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isc_read_tree (
   input  wire logic                          clock,
   input  wire logic [isc_pkg::DATA_W-1:0]    taps [isc_pkg::CAPACITY],
   output logic      [isc_pkg::DATA_W-1:0]    read_data
);

   logic [isc_pkg::DATA_W-1:0] group_ff [isc_pkg::NGROUP];
   logic [isc_pkg::DATA_W-1:0] group_in [isc_pkg::NGROUP];
   logic [isc_pkg::DATA_W-1:0] sum_ff;
   logic [isc_pkg::DATA_W-1:0] sum_in;

   always_comb begin
      for (int g = 0; g < isc_pkg::NGROUP; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < isc_pkg::GROUP; j++) begin
            if (g * isc_pkg::GROUP + j < isc_pkg::CAPACITY) begin
               group_in[g] = group_in[g] | taps[g * isc_pkg::GROUP + j];
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < isc_pkg::NGROUP; g++) begin
         sum_in = sum_in | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      sum_ff   <= sum_in;
   end

   assign read_data = sum_ff;

endmodule

`default_nettype wire

[rtl/indexed_sequence_store.sv]
// indexed_sequence_store: top level; command decode, element count, result
// register and the row of isc_cell entries. Depends on isc_pkg, isc_cell,
// isc_read_tree.
//
//   channel   dir   handshake             payload
//   req       in    req_valid/req_stall   req_cmd, req_position, req_item_value
//   rsp       out   rsp_valid/rsp_stall   rsp_read_value, rsp_status, rsp_length
//
// one item at a time. inserts and deletes shift the row at and past their
// position in the accept cycle; refused and spare commands leave it. for all
// but a valid read the result is valid the next cycle. a valid read goes
// through the two registered or-levels of the read tree (S_READ1, S_READ2).
// reset clears the element count, the state and rsp_valid; entries need no clearing.
// req_stall is high from accept until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module indexed_sequence_store (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic        [isc_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic signed [isc_pkg::POS_W-1:0]    req_position,
   input  wire logic signed [isc_pkg::DATA_W-1:0]   req_item_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed      [isc_pkg::DATA_W-1:0]   rsp_read_value,
   output logic             [isc_pkg::STAT_W-1:0]   rsp_status,
   output logic             [isc_pkg::LEN_W-1:0]    rsp_length
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ1,
      S_READ2,
      S_HOLD
   } state_type;

   state_type                         state_ff;
   logic [isc_pkg::CNT_W-1:0]         count_ff;
   logic [isc_pkg::CNT_W-1:0]         count_in;
   logic                              rsp_valid_ff;
   logic signed [isc_pkg::DATA_W-1:0] rsp_read_value_ff;
   logic [isc_pkg::STAT_W-1:0]        rsp_status_ff;
   logic [isc_pkg::LEN_W-1:0]         rsp_length_ff;

   logic                              accept;
   logic                              negative;
   logic [isc_pkg::POS_W-2:0]         idx;
   logic [isc_pkg::POS_W-2:0]         count_ext;
   logic                              full;
   logic                              read_ok;
   isc_pkg::status_type               status_in;
   isc_pkg::cell_ctrl_type            ctrl;

   logic [isc_pkg::DATA_W-1:0]        cell_q   [isc_pkg::CAPACITY];
   logic [isc_pkg::DATA_W-1:0]        cell_tap [isc_pkg::CAPACITY];
   logic [isc_pkg::DATA_W-1:0]        tree_data;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   assign negative  = req_position[isc_pkg::POS_W-1];
   assign idx       = req_position[isc_pkg::POS_W-2:0];
   assign count_ext = (isc_pkg::POS_W-1)'(count_ff);
   assign full      = (count_ff == isc_pkg::CNT_W'(isc_pkg::CAPACITY));

   always_comb begin
      ctrl.op       = isc_pkg::OP_HOLD;
      ctrl.pos      = idx[isc_pkg::IDX_W-1:0];
      ctrl.value    = req_item_value;
      ctrl.read_pos = idx[isc_pkg::IDX_W-1:0];
      count_in      = count_ff;
      status_in     = isc_pkg::ST_DONE;
      read_ok       = 1'b0;
      unique case (isc_pkg::cmd_type'(req_cmd))
         isc_pkg::CMD_READ: begin
            if (negative || idx >= count_ext) begin
               status_in = isc_pkg::ST_RANGE;
            end else begin
               read_ok = 1'b1;
            end
         end
         isc_pkg::CMD_HEAD: begin
            if (full) begin
               status_in = isc_pkg::ST_FULL;
            end else begin
               ctrl.op  = isc_pkg::OP_INSERT;
               ctrl.pos = '0;
               count_in = count_ff + 1'b1;
            end
         end
         isc_pkg::CMD_TAIL: begin
            if (full) begin
               status_in = isc_pkg::ST_FULL;
            end else begin
               ctrl.op  = isc_pkg::OP_INSERT;
               ctrl.pos = count_ff[isc_pkg::IDX_W-1:0];
               count_in = count_ff + 1'b1;
            end
         end
         isc_pkg::CMD_AT: begin
            // index is checked before fullness
            if (negative || idx > count_ext) begin
               status_in = isc_pkg::ST_RANGE;
            end else if (full) begin
               status_in = isc_pkg::ST_FULL;
            end else begin
               ctrl.op  = isc_pkg::OP_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         isc_pkg::CMD_DELETE: begin
            if (negative || idx >= count_ext) begin
               status_in = isc_pkg::ST_RANGE;
            end else begin
               ctrl.op  = isc_pkg::OP_DELETE;
               count_in = count_ff - 1'b1;
            end
         end
         default: status_in = isc_pkg::ST_DONE;
      endcase
      if (!accept) begin
         ctrl.op = isc_pkg::OP_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  count_ff          <= count_in;
                  rsp_status_ff     <= status_in;
                  rsp_length_ff     <= isc_pkg::LEN_W'(count_in);
                  rsp_read_value_ff <= '1;
                  if (read_ok) begin
                     state_ff <= S_READ1;
                  end else begin
                     state_ff     <= S_HOLD;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_READ1: begin
               state_ff <= S_READ2;
            end
            S_READ2: begin
               rsp_read_value_ff <= tree_data;
               rsp_valid_ff      <= 1'b1;
               state_ff          <= S_HOLD;
            end
            S_HOLD: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_length     = rsp_length_ff;

   for (genvar k = 0; k < isc_pkg::CAPACITY; k++) begin : g_cell
      logic [isc_pkg::DATA_W-1:0] left_value;
      logic [isc_pkg::DATA_W-1:0] right_value;

      if (k == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_q[k-1];
      end

      if (k == isc_pkg::CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_q[k+1];
      end

      isc_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_idx    (isc_pkg::IDX_W'(k)),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_q[k]),
         .read_tap    (cell_tap[k])
      );
   end

   isc_read_tree u_read_tree (
      .clock     (clock),
      .taps      (cell_tap),
      .read_data (tree_data)
   );

endmodule

`default_nettype wire

[test/indexed_sequence_store_tb.sv]
`timescale 1ns / 1ps
// indexed_sequence_store_tb: directed command table, then a grow / shrink / mixed
// random command stream, each result checked against its fixed table outcome or a
// local sequence model. Depends on isc_pkg and the indexed_sequence_store RTL.

module indexed_sequence_store_tb;
   import isc_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_SPARE_5  = 3'd5;
   localparam logic [CMD_W-1:0]     CMD_SPARE_6  = 3'd6;
   localparam logic [CMD_W-1:0]     CMD_SPARE_7  = 3'd7;
   localparam logic signed [DATA_W-1:0] NO_VALUE = -32'sd1;
   localparam logic signed [POS_W-1:0]  POS_MIN  = 16'h8000;
   localparam logic signed [POS_W-1:0]  POS_MAX  = 16'h7fff;
   localparam int RANDOM_ITEMS = 700;
   localparam int GROW_END     = 400;
   localparam int SHRINK_END   = 650;
   // worst item: the idle gap on the sender, the time in the block and the stall on
   // the receiver; the limit is many times that
   localparam int IDLE_LIMIT   = 200;
   localparam int MAX_REPORTS  = 100;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      status_type               status;
      logic [LEN_W-1:0]         length;
   } outcome_type;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [POS_W-1:0]  position;
      logic signed [DATA_W-1:0] item_value;
      logic                     fixed;
      outcome_type              outcome;
   } stim_row_type;

   localparam outcome_type PREDICTED = '{NO_VALUE, ST_DONE, 9'd0};

   // fixed rows carry a result that is plain from the command alone
   localparam stim_row_type DIRECTED_ROWS [0:24] = '{
      '{CMD_READ,    16'sd0,  32'sd0,        1'b1, '{NO_VALUE, ST_RANGE, 9'd0}},
      '{CMD_DELETE,  16'sd0,  32'sd0,        1'b1, '{NO_VALUE, ST_RANGE, 9'd0}},
      '{CMD_AT,      16'sd1,  32'sd9,        1'b1, '{NO_VALUE, ST_RANGE, 9'd0}},
      '{CMD_AT,      -16'sd1, 32'sd9,        1'b1, '{NO_VALUE, ST_RANGE, 9'd0}},
      '{CMD_AT,      16'sd0,  32'sd5,        1'b1, '{NO_VALUE, ST_DONE,  9'd1}},
      '{CMD_HEAD,    16'sd0,  32'h7fff_ffff, 1'b1, '{NO_VALUE, ST_DONE,  9'd2}},
      '{CMD_TAIL,    POS_MAX, 32'h8000_0000, 1'b1, '{NO_VALUE, ST_DONE,  9'd3}},
      '{CMD_AT,      16'sd3,  32'hffff_ffff, 1'b1, '{NO_VALUE, ST_DONE,  9'd4}},
      '{CMD_AT,      16'sd1,  32'h1234_5678, 1'b0, PREDICTED},
      '{CMD_READ,    16'sd0,  32'sd0,        1'b0, PREDICTED},
      '{CMD_READ,    16'sd4,  32'sd0,        1'b0, PREDICTED},
      '{CMD_READ,    16'sd5,  32'sd0,        1'b1, '{NO_VALUE, ST_RANGE, 9'd5}},
      '{CMD_READ,    POS_MIN, 32'sd0,        1'b1, '{NO_VALUE, ST_RANGE, 9'd5}},
      '{CMD_READ,    POS_MAX, 32'sd0,        1'b1, '{NO_VALUE, ST_RANGE, 9'd5}},
      '{CMD_READ,    -16'sd1, 32'sd0,        1'b1, '{NO_VALUE, ST_RANGE, 9'd5}},
      '{CMD_DELETE,  16'sd1,  32'sd0,        1'b0, PREDICTED},
      '{CMD_DELETE,  16'sd4,  32'sd0,        1'b1, '{NO_VALUE, ST_RANGE, 9'd4}},
      '{CMD_DELETE,  POS_MIN, 32'sd0,        1'b1, '{NO_VALUE, ST_RANGE, 9'd4}},
      '{CMD_SPARE_5, 16'sd0,  32'sd7,        1'b1, '{NO_VALUE, ST_DONE,  9'd4}},
      '{CMD_SPARE_6, POS_MIN, 32'hffff_ffff, 1'b1, '{NO_VALUE, ST_DONE,  9'd4}},
      '{CMD_SPARE_7, POS_MAX, 32'h8000_0000, 1'b1, '{NO_VALUE, ST_DONE,  9'd4}},
      '{CMD_AT,      POS_MAX, 32'sd1,        1'b1, '{NO_VALUE, ST_RANGE, 9'd4}},
      '{CMD_READ,    16'sd2,  32'sd0,        1'b0, PREDICTED},
      '{CMD_DELETE,  16'sd0,  32'sd0,        1'b0, PREDICTED},
      '{CMD_HEAD,    16'sd0,  32'sd0,        1'b0, PREDICTED}
   };

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_cmd;
   logic signed [POS_W-1:0]  req_position;
   logic signed [DATA_W-1:0] req_item_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [STAT_W-1:0]        rsp_status;
   logic [LEN_W-1:0]         rsp_length;

   // local copy of the sequence, entries 0 .. seq_count-1 are live
   logic signed [DATA_W-1:0] seq_mem [0:CAPACITY-1];
   int                       seq_count = 0;
   outcome_type              pending_results [$];
   int                       mismatch_count = 0;
   bit                       quiet_run = 1'b0;

   indexed_sequence_store uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int draw_gap();
      return quiet_run ? 0 : int'($urandom_range(0, 5));
   endfunction

   function automatic void seq_insert(int at, logic signed [DATA_W-1:0] value);
      for (int k = seq_count; k > at; k--)
         seq_mem[k] = seq_mem[k - 1];
      seq_mem[at] = value;
      seq_count++;
   endfunction

   function automatic outcome_type apply_command(logic [CMD_W-1:0] cmd,
                                                 logic signed [POS_W-1:0] position,
                                                 logic signed [DATA_W-1:0] value);
      outcome_type o;
      int          idx;
      bit          full;
      idx = int'(position);
      full = (seq_count >= CAPACITY);
      o.read_value = NO_VALUE;
      o.status = ST_DONE;
      case (cmd)
         CMD_READ: begin
            if (idx < 0 || idx >= seq_count) o.status = ST_RANGE;
            else o.read_value = seq_mem[idx];
         end
         CMD_HEAD: begin
            if (full) o.status = ST_FULL;
            else seq_insert(0, value);
         end
         CMD_TAIL: begin
            if (full) o.status = ST_FULL;
            else seq_insert(seq_count, value);
         end
         CMD_AT: begin
            // index is checked before the full store
            if (idx < 0 || idx > seq_count) o.status = ST_RANGE;
            else if (full) o.status = ST_FULL;
            else seq_insert(idx, value);
         end
         CMD_DELETE: begin
            if (idx < 0 || idx >= seq_count) begin
               o.status = ST_RANGE;
            end else begin
               for (int k = idx; k + 1 < seq_count; k++)
                  seq_mem[k] = seq_mem[k + 1];
               seq_count--;
            end
         end
         default: ;
      endcase
      o.length = LEN_W'(seq_count);
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS)
         $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // returns at the edge where the item is taken
   task automatic send_item(input logic [CMD_W-1:0] cmd,
                            input logic signed [POS_W-1:0] position,
                            input logic signed [DATA_W-1:0] value,
                            input logic fixed,
                            input outcome_type fixed_outcome);
      int          gap;
      outcome_type predicted;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_position   <= position;
      req_item_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = apply_command(cmd, position, value);
      pending_results.push_back(fixed ? fixed_outcome : predicted);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin : result_side
      int          gap;
      outcome_type want;
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset);
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_value !== want.read_value)
               report_mismatch($sformatf("read_value %0d, expected %0d",
                                         rsp_read_value, want.read_value));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, want.status));
            if (rsp_length !== want.length)
               report_mismatch($sformatf("length %0d, expected %0d",
                                         rsp_length, want.length));
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("indexed_sequence_store regression: fail");
      $finish;
   end

   initial begin : command_side
      int                       roll;
      int                       pick;
      int                       insert_pct;
      logic [CMD_W-1:0]         cmd;
      logic signed [POS_W-1:0]  position;
      logic signed [DATA_W-1:0] value;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cmd        <= CMD_READ;
      req_position   <= '0;
      req_item_value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].position,
                   DIRECTED_ROWS[i].item_value, DIRECTED_ROWS[i].fixed,
                   DIRECTED_ROWS[i].outcome);
      wait_for_results();

      // grow until the store fills and refuses, then shrink it, then mix
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == GROW_END) wait_for_results();
         quiet_run = (n % 100) < 15;
         insert_pct = (n < GROW_END) ? 80 : (n < SHRINK_END) ? 10 : 45;
         roll = $urandom_range(0, 99);
         if (roll < insert_pct) begin
            case ($urandom_range(0, 2))
               0: cmd = CMD_HEAD;
               1: cmd = CMD_TAIL;
               default: cmd = CMD_AT;
            endcase
         end else if (roll < insert_pct + 12) begin
            cmd = CMD_READ;
         end else if (roll < insert_pct + 15) begin
            cmd = CMD_SPARE_5 + CMD_W'($urandom_range(0, 2));
         end else begin
            cmd = CMD_DELETE;
         end

         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            if (cmd == CMD_READ || cmd == CMD_DELETE)
               position = (seq_count > 0) ? POS_W'($urandom_range(0, seq_count - 1)) : '0;
            else
               position = POS_W'($urandom_range(0, seq_count));
         end else if (pick < 83) begin
            position = POS_W'(seq_count);
         end else if (pick < 91) begin
            position = POS_W'($urandom);
         end else if (pick < 96) begin
            position = -16'sd1 - POS_W'($urandom_range(0, 3));
         end else begin
            position = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
         end

         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: value = 32'h8000_0000;
               1: value = 32'h7fff_ffff;
               2: value = '1;
               default: value = '0;
            endcase
         end else begin
            value = $urandom;
         end

         send_item(cmd, position, value, 1'b0, PREDICTED);
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("indexed_sequence_store regression: pass");
      else
         $display("indexed_sequence_store regression: fail");
      $finish;
   end

endmodule
